@@ rtl/core/tea_pkg.sv @@
// Shared types, constants and the round mixing function for the TEA engine.
// No dependencies; imported by every module of the engine.
package tea_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BLOCK_W = 2 * WORD_W;
	localparam int unsigned ROUND_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0]  TEA_DELTA = 32'h9e3779b9;
	localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 8'd32;
	// starting sum for decryption at the reset round count
	localparam logic [WORD_W-1:0]  DEC_SUM_RESET = 32'(TEA_DELTA * ROUND_COUNT_RESET);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

	// input command codes
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} tea_state_t;

	typedef struct packed {
		logic load;          // capture the accepted block and seed the sum
		logic step;          // apply one round pair to the working halves
		logic out_wr;        // write the output register
		logic out_sel_round; // output takes the round result, else the working halves
	} tea_cmd_t;

	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] h,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((h << 4) + ka) ^ (h + s) ^ ((h >> 5) + kb);
	endfunction

endpackage

@@ rtl/core/tea_ctrl.sv @@
// Sequencing controller for the TEA engine: round counter, state machine,
// output valid flag. Depends on tea_pkg.
module tea_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_we,
	input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tea_pkg::ROUND_W-1:0]    cfg_rounds,
	output tea_pkg::tea_cmd_t              cmd
);
	import tea_pkg::*;

	tea_state_t           state_q;
	tea_state_t           state_d;
	logic [ROUND_W-1:0]   round_count_q;
	logic [ROUND_W-1:0]   count_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 last_round;
	logic                 accept;

	assign out_free   = !out_valid_q || m_tready;
	assign last_round = (count_q == ROUND_W'(1));
	assign accept     = s_tvalid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (round_count_q == '0) ? ST_HOLD : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_round) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready          = 1'b0;
		cmd.load          = 1'b0;
		cmd.step          = 1'b0;
		cmd.out_wr        = 1'b0;
		cmd.out_sel_round = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.step          = 1'b1;
				cmd.out_sel_round = 1'b1;
				cmd.out_wr        = last_round && out_free;
			end
			ST_HOLD: begin
				cmd.out_wr = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_count_q <= ROUND_COUNT_RESET;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_ROUNDS) begin
				round_count_q <= cfg_rounds;
			end
			if (accept) begin
				count_q <= round_count_q;
			end else if (state_q == ST_RUN) begin
				count_q <= count_q - ROUND_W'(1);
			end
			// hold a result until its transfer
			if (cmd.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ rtl/core/tea_dpath.sv @@
// Datapath for the TEA engine: key registers, working halves, running sum
// and one round pair of mixing logic, plus the output register. Depends on tea_pkg.
module tea_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tea_pkg::tea_cmd_t              cmd,
	input  logic                           command,
	input  logic [tea_pkg::BLOCK_W-1:0]    block_in,
	output logic [tea_pkg::BLOCK_W-1:0]    block_out,
	input  logic                           cfg_we,
	input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tea_pkg::WORD_W-1:0]     cfg_data
);
	import tea_pkg::*;

	logic [WORD_W-1:0]  key0_q;
	logic [WORD_W-1:0]  key1_q;
	logic [WORD_W-1:0]  key2_q;
	logic [WORD_W-1:0]  key3_q;
	logic [WORD_W-1:0]  dec_sum_q;
	logic [WORD_W-1:0]  y_q;
	logic [WORD_W-1:0]  z_q;
	logic [WORD_W-1:0]  sum_q;
	logic               dec_q;
	logic [BLOCK_W-1:0] out_q;

	logic [WORD_W-1:0]  enc_y;
	logic [WORD_W-1:0]  enc_z;
	logic [WORD_W-1:0]  dec_y;
	logic [WORD_W-1:0]  dec_z;
	logic [WORD_W-1:0]  y_d;
	logic [WORD_W-1:0]  z_d;
	logic [WORD_W-1:0]  sum_d;

	// one round pair in each direction from the same working halves
	always_comb begin
		enc_y = y_q + tea_mix(z_q, sum_q, key0_q, key1_q);
		enc_z = z_q + tea_mix(enc_y, sum_q, key2_q, key3_q);
		dec_z = z_q - tea_mix(y_q, sum_q, key2_q, key3_q);
		dec_y = y_q - tea_mix(dec_z, sum_q, key0_q, key1_q);
		y_d   = (dec_q == CMD_DECRYPT) ? dec_y : enc_y;
		z_d   = (dec_q == CMD_DECRYPT) ? dec_z : enc_z;
		sum_d = (dec_q == CMD_DECRYPT) ? (sum_q - TEA_DELTA) : (sum_q + TEA_DELTA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q    <= '0;
			key1_q    <= '0;
			key2_q    <= '0;
			key3_q    <= '0;
			dec_sum_q <= DEC_SUM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY0:   key0_q <= cfg_data;
				CFG_KEY1:   key1_q <= cfg_data;
				CFG_KEY2:   key2_q <= cfg_data;
				CFG_KEY3:   key3_q <= cfg_data;
				// precompute the decrypt starting sum, delta times round count
				CFG_ROUNDS: dec_sum_q <= WORD_W'(TEA_DELTA * {24'd0, cfg_data[ROUND_W-1:0]});
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q   <= block_in[WORD_W-1:0];
			z_q   <= block_in[BLOCK_W-1:WORD_W];
			dec_q <= command;
			sum_q <= (command == CMD_DECRYPT) ? dec_sum_q : TEA_DELTA;
		end else if (cmd.step) begin
			y_q   <= y_d;
			z_q   <= z_d;
			sum_q <= sum_d;
		end
		if (cmd.out_wr) begin
			out_q <= cmd.out_sel_round ? {z_d, y_d} : {z_q, y_q};
		end
	end

	assign block_out = out_q;

endmodule

@@ rtl/core/tea_block_cipher_engine.sv @@
// TEA block cipher engine, top level: stream ports, configuration port.
// Depends on tea_pkg, tea_ctrl and tea_dpath.
//
// The engine encrypts (tuser 0) or decrypts (tuser 1) one 64-bit block at a
// time with a 128-bit key and a programmable count of round pairs (0 to 255,
// 32 after reset); the low word of tdata is the first half of the block.
// One round pair is computed per clock. The result is written in the last round,
// or from the hold state with a round count of zero or a full output register,
// and the next block can be taken in the cycle after the write. The next block is
// taken as soon as the result sits in the output register, even if that result
// is not yet taken; it waits only when a new result finds the output register
// still full. Configuration may be written only while no block is in flight.
module tea_block_cipher_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tea_pkg::BLOCK_W-1:0]    s_tdata,  // [63:0] block_in
	input  logic                           s_tuser,  // [0] command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tea_pkg::BLOCK_W-1:0]    m_tdata,  // [63:0] block_out
	input  logic                           cfg_we,
	input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tea_pkg::WORD_W-1:0]     cfg_data
);
	import tea_pkg::*;

	tea_cmd_t cmd;

	tea_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_rounds (cfg_data[ROUND_W-1:0]),
		.cmd        (cmd)
	);

	tea_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.command   (s_tuser),
		.block_in  (s_tdata),
		.block_out (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |-> (!m_tvalid || m_tready))
		else $error("output register written while holding an untaken result");

	// an input transfer never coincides with a round step or a result write
	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!cmd.out_wr && !cmd.step))
		else $error("input transfer overlaps round or output write");

	// the engine is not ready in the cycle after an input transfer
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("engine ready right after taking a block");

	// a result write always produces a valid output next cycle
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |=> m_tvalid)
		else $error("result written but output not valid");

endmodule

@@ sim/tb_top.sv @@
// Testbench for tea_block_cipher_engine: random and directed blocks, keys and round counts,
// checked against a bit-exact TEA predictor in a scoreboard class.
// Depends on tea_pkg and the engine RTL.
module tb_top;
	import tea_pkg::*;

	localparam int IDLE_PCT     = 31;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 4;
	localparam int DRAIN_CYCLES = 264;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 70;
	localparam int CALM_PHASE   = 4;
	localparam int HOLD_PHASE   = 7;

	class tea_scoreboard;
		bit [WORD_W-1:0]  key_words [4];
		bit [ROUND_W-1:0] rounds;
		bit [BLOCK_W-1:0] expected_blocks [$];
		bit [BLOCK_W-1:0] last_block;
		bit               last_cmd;
		int               errors;

		function new();
			rounds = ROUND_COUNT_RESET;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
			case (idx)
				CFG_KEY0:   key_words[0] = val;
				CFG_KEY1:   key_words[1] = val;
				CFG_KEY2:   key_words[2] = val;
				CFG_KEY3:   key_words[3] = val;
				CFG_ROUNDS: rounds = val[ROUND_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [WORD_W-1:0] feistel_f(bit [WORD_W-1:0] h, bit [WORD_W-1:0] s,
				bit [WORD_W-1:0] ka, bit [WORD_W-1:0] kb);
			return ((h << 4) + ka) ^ (h + s) ^ ((h >> 5) + kb);
		endfunction

		function bit [BLOCK_W-1:0] cipher_block(bit cmd, bit [BLOCK_W-1:0] blk);
			bit [WORD_W-1:0] y;
			bit [WORD_W-1:0] z;
			bit [WORD_W-1:0] sum;
			y = blk[WORD_W-1:0];
			z = blk[BLOCK_W-1:WORD_W];
			if (cmd == CMD_ENCRYPT) begin
				sum = '0;
				for (int i = 0; i < rounds; i++) begin
					sum += TEA_DELTA;
					y += feistel_f(z, sum, key_words[0], key_words[1]);
					z += feistel_f(y, sum, key_words[2], key_words[3]);
				end
			end else begin
				sum = TEA_DELTA * {{(WORD_W-ROUND_W){1'b0}}, rounds};
				for (int i = 0; i < rounds; i++) begin
					z -= feistel_f(y, sum, key_words[2], key_words[3]);
					y -= feistel_f(z, sum, key_words[0], key_words[1]);
					sum -= TEA_DELTA;
				end
			end
			return {z, y};
		endfunction

		function void note_block(bit cmd, bit [BLOCK_W-1:0] blk);
			last_block = cipher_block(cmd, blk);
			last_cmd = cmd;
			expected_blocks.push_back(last_block);
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_block(logic [BLOCK_W-1:0] got);
			bit [BLOCK_W-1:0] want;
			if (expected_blocks.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				want = expected_blocks.pop_front();
				if (got !== want)
					report($sformatf("block_out %h, expected %h", got, want));
			end
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [BLOCK_W-1:0]   s_tdata   = '0;
	logic                 s_tuser   = CMD_ENCRYPT;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [BLOCK_W-1:0]   m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	tea_scoreboard sb = new();
	bit tx_idle  = 1'b1;
	bit rx_idle  = 1'b1;
	bit hold_req = 1'b0;
	int cycle_count = 0;

	tea_block_cipher_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result side: check each transfer, then pick the next tready.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_block(m_tdata);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(rx_idle && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task program_engine(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
			input logic [WORD_W-1:0] round_word, input bit spare);
		write_reg(CFG_KEY0, k0);
		write_reg(CFG_KEY1, k1);
		write_reg(CFG_KEY2, k2);
		write_reg(CFG_KEY3, k3);
		write_reg(CFG_ROUNDS, round_word);
		// unmapped indexes must leave every register alone
		if (spare)
			for (int i = CFG_ROUNDS + 1; i < (1 << CFG_IDX_W); i++)
				write_reg(CFG_IDX_W'(i), $urandom);
		cfg_we <= 1'b0;
	endtask

	task send_block(input logic cmd, input logic [BLOCK_W-1:0] blk);
		if (tx_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (tx_idle && $urandom_range(99) < IDLE_PCT);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= blk;
		do @(posedge clk); while (!s_tready);
		sb.note_block(cmd, blk);
	endtask

	// Drop valid and wait until every result has been taken.
	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_key();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task run_random_phase(input int n_items, input bit low_rounds);
		logic [ROUND_W-1:0] r;
		logic               cmd;
		logic [BLOCK_W-1:0] blk;
		case ($urandom_range(9))
			0:       r = '0;
			1:       r = 8'd1;
			2:       r = '1;
			default: r = ROUND_W'($urandom_range(40, 2));
		endcase
		if (low_rounds)
			r = ROUND_W'($urandom_range(8));
		program_engine(pick_key(), pick_key(), pick_key(), pick_key(),
			{(WORD_W-ROUND_W)'($urandom), r}, $urandom_range(3) == 0);
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(9))
				0: begin
					cmd = 1'($urandom_range(1));
					blk = $urandom_range(1) ? '1 : '0;
				end
				1: begin
					// feed back the previous result the other way round
					cmd = !sb.last_cmd;
					blk = sb.last_block;
				end
				default: begin
					cmd = 1'($urandom_range(1));
					blk = {$urandom, $urandom};
				end
			endcase
			send_block(cmd, blk);
		end
		drain();
	endtask

	initial begin : stimulus
		logic [BLOCK_W-1:0] plain;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero key, 32 round pairs
		send_block(CMD_ENCRYPT, '0);
		send_block(CMD_DECRYPT, '0);
		send_block(CMD_ENCRYPT, '1);
		drain();

		// all-ones key, longest round count
		program_engine('1, '1, '1, '1, 32'h0000_00ff, 1'b0);
		send_block(CMD_ENCRYPT, '1);
		send_block(CMD_DECRYPT, '0);
		send_block(CMD_ENCRYPT, 64'h8000_0000_0000_0001);
		drain();

		// zero rounds through a wide write: upper bits must be dropped
		program_engine('0, '1, '0, '1, 32'hffff_ff00, 1'b0);
		send_block(CMD_ENCRYPT, 64'h0123_4567_89ab_cdef);
		send_block(CMD_DECRYPT, '1);
		drain();

		// one round pair; unmapped indexes written with noise
		program_engine($urandom, $urandom, $urandom, $urandom, 32'h0000_0001, 1'b1);
		send_block(CMD_ENCRYPT, {$urandom, $urandom});
		send_block(CMD_DECRYPT, {$urandom, $urandom});
		drain();

		// round trip at 32 rounds with a textbook-style key
		program_engine(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210,
			32'habcd_ef20, 1'b0);
		plain = {$urandom, $urandom};
		send_block(CMD_ENCRYPT, plain);
		send_block(CMD_DECRYPT, sb.last_block);
		send_block(CMD_ENCRYPT, 64'hffff_ffff_0000_0000);
		send_block(CMD_DECRYPT, 64'h0000_0000_ffff_ffff);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			tx_idle = (p != CALM_PHASE);
			rx_idle = (p != CALM_PHASE);
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			run_random_phase(PHASE_ITEMS, p == HOLD_PHASE);
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
